// File: rtl/core/per_channel_moving_average_alarm_defines.svh
// Assertion macros shared by the moving-average alarm RTL.
`ifndef PER_CHANNEL_MOVING_AVERAGE_ALARM_DEFINES_SVH
`define PER_CHANNEL_MOVING_AVERAGE_ALARM_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define PCMAA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcmaa assertion failed");
// Next-cycle implication, disabled during reset.
`define PCMAA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcmaa assertion failed");
`else
`define PCMAA_ASSERT_IMP(label, clk, rst, ante, cons)
`define PCMAA_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// File: rtl/core/pcmaa_pkg.sv
// Shared types and constants of the moving-average alarm.
package pcmaa_pkg;

   localparam int CHAN_W      = 8;
   localparam int DATA_W      = 32;
   localparam int FILL_OUT_W  = 3;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;
   // quotient bits produced per divider cycle
   localparam int DIV_DIGITS  = 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_UPDATE,
      ST_DIVIDE,
      ST_OUTPUT
   } pcmaa_state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic fetch;
      logic update;
      logic div_step;
      logic load_out;
   } pcmaa_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic req_ok;
      logic div_last;
      logic out_free;
   } pcmaa_stat_type;

endpackage

// File: rtl/core/per_channel_moving_average_alarm.sv
// Top level of the per-channel moving-average alarm.
//
// Each item carries a channel and a signed Q16.16 sample; the block keeps the
// last WINDOW_LEN samples of every channel and returns, one result per item,
// the channel, the window average (truncated toward zero), the fill count and
// an alarm flag set when the exact average exceeds 0.75 of threshold_level.
// An item passes through a read of the channel record memory, a read of the
// sample memory, a write of both memories, then an eight-bits-per-cycle
// divider that forms the average. The next item is taken once the previous
// result sits in the output register; the block stalls only when that
// register is still full. Channel state is marked empty by reset at once,
// with no clearing pass. Samples for channels at or above NUM_CHANNELS are
// taken and produce nothing.
module per_channel_moving_average_alarm #(
   parameter int NUM_CHANNELS = 256,
   parameter int WINDOW_LEN   = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: channel [7:0], sample_value [39:8]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [pcmaa_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // rsp_tdata: channel_out [7:0], window_average [39:8], window_fill [42:40],
   // over_threshold [43], zero [47:44]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [pcmaa_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // threshold_level, signed Q16.16
   input  logic                                 csr_we,
   input  logic [pcmaa_pkg::DATA_W-1:0]         csr_wdata
);
   import pcmaa_pkg::*;

   pcmaa_cmd_type            cmd;
   pcmaa_stat_type           stat;
   logic signed [DATA_W-1:0] threshold_level_ff;
   logic [CHAN_W-1:0]        req_channel;
   logic signed [DATA_W-1:0] req_sample;
   logic [CHAN_W-1:0]        rsp_channel;
   logic [DATA_W-1:0]        rsp_average;
   logic [FILL_OUT_W-1:0]    rsp_fill;
   logic                     rsp_over;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_level_ff <= '0;
      end else if (csr_we) begin
         threshold_level_ff <= signed'(csr_wdata);
      end
   end

   // item unpacking and packing
   assign req_channel = req_tdata[CHAN_W-1:0];
   assign req_sample  = signed'(req_tdata[CHAN_W +: DATA_W]);
   assign rsp_tdata   = {(RSP_TDATA_W - CHAN_W - DATA_W - FILL_OUT_W - 1)'(0),
                         rsp_over, rsp_fill, rsp_average, rsp_channel};

   pcmaa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pcmaa_dp #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .WINDOW_LEN   (WINDOW_LEN)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_channel     (req_channel),
      .req_sample      (req_sample),
      .threshold_level (threshold_level_ff),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_channel     (rsp_channel),
      .rsp_average     (rsp_average),
      .rsp_fill        (rsp_fill),
      .rsp_over        (rsp_over)
   );

endmodule

// File: rtl/core/pcmaa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pcmaa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/pcmaa_ctrl.sv
// Sequencing state machine: fetch, update, divide, deliver.
`include "per_channel_moving_average_alarm_defines.svh"

module pcmaa_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  pcmaa_pkg::pcmaa_stat_type stat,
   output pcmaa_pkg::pcmaa_cmd_type  cmd
);
   import pcmaa_pkg::*;

   pcmaa_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            // out-of-range channels are taken and dropped
            if (req_tvalid && stat.req_ok) state_in = ST_FETCH;
         end
         ST_FETCH:  state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (stat.div_last) state_in = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_FETCH:  cmd.fetch    = 1'b1;
         ST_UPDATE: cmd.update   = 1'b1;
         ST_DIVIDE: cmd.div_step = 1'b1;
         ST_OUTPUT: cmd.load_out = stat.out_free;
         default: cmd = '0;
      endcase
   end

   `PCMAA_ASSERT_NXT(a_accept_fetch, clock, reset, cmd.accept && stat.req_ok, state_ff == ST_FETCH)
   `PCMAA_ASSERT_NXT(a_div_done, clock, reset, state_ff == ST_DIVIDE && stat.div_last, state_ff == ST_OUTPUT)

endmodule

// File: rtl/core/pcmaa_dp.sv
// Datapath: channel records, sample windows, divider, alarm compare, result register.
`include "per_channel_moving_average_alarm_defines.svh"

module pcmaa_dp #(
   parameter int NUM_CHANNELS = 256,
   parameter int WINDOW_LEN   = 5
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pcmaa_pkg::pcmaa_cmd_type               cmd,
   output pcmaa_pkg::pcmaa_stat_type              stat,
   input  logic [pcmaa_pkg::CHAN_W-1:0]           req_channel,
   input  logic signed [pcmaa_pkg::DATA_W-1:0]    req_sample,
   input  logic signed [pcmaa_pkg::DATA_W-1:0]    threshold_level,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [pcmaa_pkg::CHAN_W-1:0]           rsp_channel,
   output logic [pcmaa_pkg::DATA_W-1:0]           rsp_average,
   output logic [pcmaa_pkg::FILL_OUT_W-1:0]       rsp_fill,
   output logic                                   rsp_over
);
   import pcmaa_pkg::*;

   // only 2^CHAN_W channels are reachable through the port
   localparam int CHAN_DEPTH  = (NUM_CHANNELS < (1 << CHAN_W)) ? NUM_CHANNELS : (1 << CHAN_W);
   localparam int CHAN_AW     = (CHAN_DEPTH > 1) ? $clog2(CHAN_DEPTH) : 1;
   localparam int STORE_DEPTH = CHAN_DEPTH * WINDOW_LEN;
   localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int TOTAL_W     = DATA_W + $clog2(WINDOW_LEN);
   localparam int FILL_W      = $clog2(WINDOW_LEN + 1);
   localparam int SLOT_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int REC_W       = TOTAL_W + FILL_W + SLOT_W;
   localparam int DIV_CYC     = (TOTAL_W + DIV_DIGITS - 1) / DIV_DIGITS;
   localparam int DIV_W       = DIV_CYC * DIV_DIGITS;
   localparam int CNT_W       = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
   localparam int REM_W       = FILL_W + 1;
   localparam int MUL_FW      = FILL_W + 2;
   localparam int PROD_W      = DATA_W + MUL_FW + 1;
   localparam int CMP_W       = TOTAL_W + 8;

   // item registers
   logic [CHAN_W-1:0]         ch_ff;
   logic signed [DATA_W-1:0]  sample_ff;
   logic [STORE_AW-1:0]       base_ff;
   logic signed [TOTAL_W-1:0] total_ff;
   logic [FILL_W-1:0]         fill_ff;
   logic [SLOT_W-1:0]         oldest_ff;
   logic [SLOT_W-1:0]         slot_ff;
   logic                      full_ff;
   logic [CHAN_DEPTH-1:0]     valid_ff;

   // divider and alarm registers
   logic [DIV_W-1:0]          div_ff, div_in;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic [CNT_W-1:0]          cnt_ff;
   logic                      neg_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic                      over_ff;

   // result register
   logic                      rsp_tvalid_ff;
   logic [CHAN_W-1:0]         rsp_channel_ff;
   logic [DATA_W-1:0]         rsp_average_ff;
   logic [FILL_OUT_W-1:0]     rsp_fill_ff;
   logic                      rsp_over_ff;

   // memory ports
   logic [REC_W-1:0]          rec_rd_data, rec_wr_data;
   logic [DATA_W-1:0]         store_rd_data;
   logic [STORE_AW-1:0]       store_rd_addr, store_wr_addr;
   logic [CHAN_AW-1:0]        ch_idx;

   // combinational values
   logic [REC_W-1:0]          rec_word;
   logic signed [TOTAL_W-1:0] cur_total;
   logic [FILL_W-1:0]         cur_fill;
   logic [SLOT_W-1:0]         cur_oldest, cur_slot;
   logic                      cur_full;
   logic signed [TOTAL_W-1:0] old_ext, samp_ext, total_new;
   logic [TOTAL_W-1:0]        total_mag;
   logic [FILL_W-1:0]         fill_new;
   logic [SLOT_W-1:0]         oldest_new;
   logic [MUL_FW-1:0]         fill_x3;
   logic signed [CMP_W-1:0]   cmp_lhs, cmp_rhs;
   logic [DATA_W-1:0]         avg_value;
   logic                      out_free;

   assign ch_idx = ch_ff[CHAN_AW-1:0];

   pcmaa_ram #(.WIDTH(REC_W), .DEPTH(CHAN_DEPTH)) u_rec_ram (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (ch_idx),
      .wr_data (rec_wr_data),
      .rd_en   (cmd.accept),
      .rd_addr (req_channel[CHAN_AW-1:0]),
      .rd_data (rec_rd_data)
   );

   pcmaa_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_store_ram (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (store_wr_addr),
      .wr_data (sample_ff),
      .rd_en   (cmd.fetch),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   // channel record as read; a never-written channel reads as empty
   always_comb begin
      rec_word   = valid_ff[ch_idx] ? rec_rd_data : '0;
      cur_total  = signed'(rec_word[REC_W-1 -: TOTAL_W]);
      cur_fill   = rec_word[SLOT_W +: FILL_W];
      cur_oldest = rec_word[SLOT_W-1:0];
      cur_full   = (cur_fill == FILL_W'(WINDOW_LEN));
      cur_slot   = cur_full ? cur_oldest : cur_fill[SLOT_W-1:0];
   end

   assign store_rd_addr = base_ff + STORE_AW'(cur_slot);
   assign store_wr_addr = base_ff + STORE_AW'(slot_ff);

   // window update: drop the oldest sample when full, add the new one
   always_comb begin
      old_ext    = full_ff ? TOTAL_W'($signed(store_rd_data)) : '0;
      samp_ext   = TOTAL_W'(sample_ff);
      total_new  = total_ff - old_ext + samp_ext;
      fill_new   = full_ff ? fill_ff : fill_ff + FILL_W'(1);
      if (!full_ff) begin
         oldest_new = oldest_ff;
      end else if (slot_ff == SLOT_W'(WINDOW_LEN - 1)) begin
         oldest_new = '0;
      end else begin
         oldest_new = slot_ff + SLOT_W'(1);
      end
      rec_wr_data = {total_new, fill_new, oldest_new};
      total_mag   = total_new[TOTAL_W-1] ? TOTAL_W'(-total_new) : TOTAL_W'(total_new);
   end

   // restoring division, DIV_DIGITS quotient bits per cycle
   always_comb begin
      logic [REM_W-1:0] r;
      logic [DIV_W-1:0] q;
      r = rem_ff;
      q = div_ff;
      for (int i = 0; i < DIV_DIGITS; i++) begin
         r = {r[REM_W-2:0], q[DIV_W-1]};
         q = {q[DIV_W-2:0], 1'b0};
         if (r >= {1'b0, fill_ff}) begin
            r    = r - {1'b0, fill_ff};
            q[0] = 1'b1;
         end
      end
      rem_in = r;
      div_in = q;
   end

   // alarm: 4 * total > 3 * v * fill
   assign fill_x3 = MUL_FW'({fill_ff, 1'b0}) + MUL_FW'(fill_ff);
   assign cmp_lhs = CMP_W'(total_ff) <<< 2;
   assign cmp_rhs = CMP_W'(prod_ff);

   assign avg_value = neg_ff ? (~div_ff[DATA_W-1:0] + DATA_W'(1)) : div_ff[DATA_W-1:0];
   assign out_free  = !rsp_tvalid_ff || rsp_tready;

   // item capture and record registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ch_ff     <= req_channel;
         sample_ff <= req_sample;
         base_ff   <= STORE_AW'(req_channel) * STORE_AW'(WINDOW_LEN);
      end
      if (cmd.fetch) begin
         total_ff  <= cur_total;
         fill_ff   <= cur_fill;
         oldest_ff <= cur_oldest;
         slot_ff   <= cur_slot;
         full_ff   <= cur_full;
      end else if (cmd.update) begin
         total_ff  <= total_new;
         fill_ff   <= fill_new;
      end
      // product and compare settle during the division
      prod_ff <= PROD_W'(threshold_level) * PROD_W'($signed({1'b0, fill_x3}));
      over_ff <= (cmp_lhs > cmp_rhs);
   end

   // divider registers
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         div_ff <= DIV_W'(total_mag);
         rem_ff <= '0;
         cnt_ff <= '0;
         neg_ff <= total_new[TOTAL_W-1];
      end else if (cmd.div_step) begin
         div_ff <= div_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   // per-channel valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.update) begin
         valid_ff[ch_idx] <= 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_channel_ff <= ch_ff;
         rsp_average_ff <= avg_value;
         rsp_fill_ff    <= FILL_OUT_W'(fill_ff);
         rsp_over_ff    <= over_ff;
      end
   end

   assign stat.req_ok   = ({1'b0, req_channel} < (CHAN_W + 1)'(CHAN_DEPTH));
   assign stat.div_last = (cnt_ff == CNT_W'(DIV_CYC - 1));
   assign stat.out_free = out_free;

   assign rsp_tvalid  = rsp_tvalid_ff;
   assign rsp_channel = rsp_channel_ff;
   assign rsp_average = rsp_average_ff;
   assign rsp_fill    = rsp_fill_ff;
   assign rsp_over    = rsp_over_ff;

   `PCMAA_ASSERT_IMP(a_load_when_free, clock, reset, cmd.load_out, !rsp_tvalid_ff || rsp_tready)
   `PCMAA_ASSERT_NXT(a_valid_after_update, clock, reset, cmd.update, valid_ff[ch_idx])
   `PCMAA_ASSERT_NXT(a_fill_range, clock, reset, cmd.update,
                     fill_ff != '0 && fill_ff <= FILL_W'(WINDOW_LEN))

endmodule

// File: tb/sv/per_channel_moving_average_alarm_test.sv
// Testbench for the per-channel moving-average alarm: random and directed samples, self-checked.
module per_channel_moving_average_alarm_test;
   import pcmaa_pkg::*;

   localparam int CHANNELS    = 256;
   localparam int WINDOW      = 5;
   localparam int DRAIN_CYCLES = 16;      // extra wait once every result is back
   localparam int HOLD_CYCLES  = 400;     // long output stall
   localparam int CYCLE_LIMIT  = 200000;

   // one expected result item
   typedef struct packed {
      logic [CHAN_W-1:0]       channel;
      logic signed [DATA_W-1:0] average;
      logic [FILL_OUT_W-1:0]   fill;
      logic                    alarm;
   } window_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [DATA_W-1:0] csr_wdata = '0;

   // shadow copy of the channel windows
   logic signed [DATA_W-1:0] window_samples [CHANNELS][WINDOW];
   longint window_total  [CHANNELS];
   int     window_fill   [CHANNELS];
   int     window_oldest [CHANNELS];
   logic signed [DATA_W-1:0] alarm_threshold = '0;

   window_result_type pending_windows [$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   logic rsp_hold_toggle = 1'b0;
   logic rsp_hold_seen = 1'b0;
   int rsp_hold_left = 0;
   logic [CHAN_W-1:0] hot_channels [8];

   per_channel_moving_average_alarm #(
      .NUM_CHANNELS(CHANNELS),
      .WINDOW_LEN  (WINDOW)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result receiver: random stalls, or a long hold-off on request
   always @(posedge clock) begin
      if (rsp_hold_toggle != rsp_hold_seen) begin
         rsp_hold_seen <= rsp_hold_toggle;
         rsp_hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // update the shadow window and work out the result for one sample
   function automatic window_result_type predict_window(input logic [CHAN_W-1:0] ch,
                                                        input logic signed [DATA_W-1:0] val);
      int slot;
      window_result_type r;
      if (window_fill[ch] < WINDOW) begin
         slot = window_fill[ch];
         window_fill[ch]++;
      end else begin
         slot = window_oldest[ch];
         window_total[ch] -= longint'(window_samples[ch][slot]);
         window_oldest[ch] = (slot + 1) % WINDOW;
      end
      window_samples[ch][slot] = val;
      window_total[ch] += longint'(val);
      r.channel = ch;
      r.average = DATA_W'(window_total[ch] / longint'(window_fill[ch]));
      r.fill    = FILL_OUT_W'(window_fill[ch]);
      // alarm uses the exact average: 4*total > 3*v*fill
      r.alarm   = (window_total[ch] * 4 >
                   longint'(alarm_threshold) * 3 * longint'(window_fill[ch]));
      return r;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch in %s: expected %0d, got %0d", name, want, got);
      end
   endtask

   // compare each result item with the oldest expectation
   always @(negedge clock) begin : rsp_compare
      window_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_windows.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result item: tdata %h", rsp_tdata);
         end else begin
            want = pending_windows.pop_front();
            check_field("channel_out", want.channel, rsp_tdata[7:0]);
            check_field("window_average", longint'($signed(want.average)),
                        longint'($signed(rsp_tdata[39:8])));
            check_field("window_fill", want.fill, rsp_tdata[42:40]);
            check_field("over_threshold", want.alarm, rsp_tdata[43]);
            check_field("tdata padding", 0, rsp_tdata[47:44]);
         end
      end
   end

   // offer one sample; returns at the edge where it is taken
   task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic signed [DATA_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {val, ch};
      do @(negedge clock); while (!req_tready);
      pending_windows.push_back(predict_window(ch, val));
      @(posedge clock);
   endtask

   // stop sending and let every outstanding result come back
   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (pending_windows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic signed [DATA_W-1:0] level);
      csr_we    <= 1'b1;
      csr_wdata <= level;
      @(posedge clock);
      csr_we    <= 1'b0;
      alarm_threshold = level;
   endtask

   // extremes, near-threshold values, or anything
   function automatic logic signed [DATA_W-1:0] pick_sample();
      longint near;
      near = (longint'(alarm_threshold) * 3) / 4 + longint'($urandom_range(64)) - 32;
      case ($urandom_range(9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3, 4: return DATA_W'(near);
         default: return $urandom();
      endcase
   endfunction

   // most samples go to a few channels so windows wrap often
   function automatic logic [CHAN_W-1:0] pick_channel();
      if ($urandom_range(99) < 80)
         return hot_channels[$urandom_range(7)];
      return CHAN_W'($urandom_range(CHANNELS - 1));
   endfunction

   // full-scale samples filling and wrapping windows, a zero sample and a mixed-bit sample
   task automatic test_window_extremes();
      repeat (6) send_sample(8'd0, 32'h7FFF_FFFF);
      repeat (6) send_sample(8'd255, 32'h8000_0000);
      send_sample(8'hA5, 32'sd0);
      send_sample(8'h5A, 32'h5555_AAAA);
      wait_for_idle();
   endtask

   // flag follows the exact average where the truncated average equals 0.75 of the threshold
   task automatic test_truncation_alarm();
      write_threshold(32'sd4);
      send_sample(8'd1, 32'sd3);
      send_sample(8'd1, 32'sd4);
      send_sample(8'd1, 32'sd5);
      // negative totals truncate toward zero
      send_sample(8'd2, -32'sd3);
      send_sample(8'd2, -32'sd4);
      wait_for_idle();
   endtask

   // largest and smallest threshold
   task automatic test_threshold_extremes();
      write_threshold(32'h7FFF_FFFF);
      repeat (20) send_sample(pick_channel(), pick_sample());
      wait_for_idle();
      write_threshold(32'h8000_0000);
      repeat (20) send_sample(pick_channel(), pick_sample());
      wait_for_idle();
   endtask

   // random traffic under one idling mix, new threshold every block
   task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                      input int items);
      send_idle_pct = sender_pct;
      rsp_idle_pct  = receiver_pct;
      for (int blk = 0; blk < 3; blk++) begin
         if ($urandom_range(1))
            write_threshold($urandom());
         else
            write_threshold($signed(DATA_W'($urandom_range(2000))) - 1000);
         repeat (items / 3) send_sample(pick_channel(), pick_sample());
         wait_for_idle();
      end
   endtask

   // receiver holds off long enough for the block to stall its input
   task automatic test_output_backpressure();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      rsp_hold_toggle <= ~rsp_hold_toggle;
      repeat (20) send_sample(hot_channels[0], pick_sample());
      wait_for_idle();
   endtask

   initial begin
      foreach (window_total[c]) begin
         window_total[c]  = 0;
         window_fill[c]   = 0;
         window_oldest[c] = 0;
      end
      foreach (hot_channels[i])
         hot_channels[i] = CHAN_W'($urandom_range(CHANNELS - 1));
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_window_extremes();
      test_truncation_alarm();
      test_threshold_extremes();
      test_random_traffic(18, 59, 450);
      test_output_backpressure();
      test_random_traffic(59, 18, 450);
      test_random_traffic(0, 0, 450);
      write_threshold(32'sd0);
      repeat (30) send_sample(pick_channel(), pick_sample());
      wait_for_idle();

      if (mismatch_count == 0 && pending_windows.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: per_channel_moving_average_alarm.f
+incdir+rtl/core
rtl/core/pcmaa_pkg.sv
rtl/core/pcmaa_ram.sv
rtl/core/pcmaa_ctrl.sv
rtl/core/pcmaa_dp.sv
rtl/core/per_channel_moving_average_alarm.sv
tb/sv/per_channel_moving_average_alarm_test.sv
